@@ rtl/core/crb_pkg.sv @@
// Shared types and constants for the connect retry backoff sequencer.
`timescale 1ns / 1ps
package crb_pkg;

	localparam int unsigned DELAY_W  = 16;
	localparam int unsigned OPCODE_W = 3;
	localparam int unsigned STATUS_W = 5;
	localparam int unsigned ACTION_W = 3;
	localparam int unsigned PHASE_W  = 2;
	localparam int unsigned APB_AW   = 3;
	localparam int unsigned APB_DW   = 32;

	localparam logic [DELAY_W-1:0] INIT_DELAY_RESET = 16'd500;
	localparam logic [DELAY_W-1:0] MAX_DELAY_RESET  = 16'd30000;

	// Upper bounds of the connect status classes.
	localparam logic [STATUS_W-1:0] STATUS_PROCEED_MAX   = 5'd3;
	localparam logic [STATUS_W-1:0] STATUS_TRANSIENT_MAX = 5'd8;

	// Register index, taken from paddr bit 2.
	localparam logic REG_INIT_DELAY = 1'b0;
	localparam logic REG_MAX_DELAY  = 1'b1;

	typedef enum logic [PHASE_W-1:0] {
		PH_DISC       = 2'd0,
		PH_CONNECTING = 2'd1,
		PH_CONNECTED  = 2'd2
	} phase_t;

	typedef enum logic [OPCODE_W-1:0] {
		OP_START    = 3'd0,
		OP_STOP     = 3'd1,
		OP_RESTART  = 3'd2,
		OP_RESULT   = 3'd3,
		OP_WRITABLE = 3'd4,
		OP_SOCK_ERR = 3'd5,
		OP_TIMER    = 3'd6
	} opcode_t;

	typedef enum logic [ACTION_W-1:0] {
		ACT_NONE      = 3'd0,
		ACT_CONNECT   = 3'd1,
		ACT_AWAIT     = 3'd2,
		ACT_CLOSE     = 3'd3,
		ACT_RETRY     = 3'd4,
		ACT_DELIVER   = 3'd5,
		ACT_PERMANENT = 3'd6
	} action_t;

	typedef struct packed {
		phase_t             phase;
		logic               want;
		logic [DELAY_W-1:0] delay;
	} link_state_t;

endpackage

@@ rtl/core/crb_evt_if.sv @@
// Event channel: one connection event per transfer.
`timescale 1ns / 1ps
interface crb_evt_if;
	import crb_pkg::*;

	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	logic [STATUS_W-1:0] connect_status;
	logic                so_error_set;
	logic                self_connected;

	modport source (output valid, opcode, connect_status, so_error_set, self_connected,
		input ready);
	modport sink (input valid, opcode, connect_status, so_error_set, self_connected,
		output ready);
endinterface

@@ rtl/core/crb_act_if.sv @@
// Action channel: one host action per transfer.
`timescale 1ns / 1ps
interface crb_act_if;
	import crb_pkg::*;

	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [DELAY_W-1:0]  retry_delay_ms;
	logic [PHASE_W-1:0]  link_state;

	modport source (output valid, action, retry_delay_ms, link_state, input ready);
	modport sink (input valid, action, retry_delay_ms, link_state, output ready);
endinterface

@@ rtl/core/crb_cfg_regs.sv @@
// APB configuration registers holding the initial and maximum retry delays.
`timescale 1ns / 1ps
module crb_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [crb_pkg::APB_AW-1:0]   paddr,
	input  logic [crb_pkg::APB_DW-1:0]   pwdata,
	output logic [crb_pkg::APB_DW-1:0]   prdata,
	output logic                         pready,
	output logic [crb_pkg::DELAY_W-1:0]  init_delay,
	output logic [crb_pkg::DELAY_W-1:0]  max_delay
);
	import crb_pkg::*;

	logic               wr_en;
	logic [DELAY_W-1:0] init_delay_q;
	logic [DELAY_W-1:0] max_delay_q;
	logic [DELAY_W-1:0] rd_val;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_delay_q <= INIT_DELAY_RESET;
			max_delay_q  <= MAX_DELAY_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_INIT_DELAY: init_delay_q <= pwdata[DELAY_W-1:0];
				REG_MAX_DELAY:  max_delay_q  <= pwdata[DELAY_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_INIT_DELAY: rd_val = init_delay_q;
			REG_MAX_DELAY:  rd_val = max_delay_q;
			default:        rd_val = '0;
		endcase
	end

	assign prdata     = {{(APB_DW-DELAY_W){1'b0}}, rd_val};
	assign init_delay = init_delay_q;
	assign max_delay  = max_delay_q;
endmodule

@@ rtl/core/crb_step.sv @@
// Next-state and action logic for one connection event.
`timescale 1ns / 1ps
module crb_step (
	input  crb_pkg::link_state_t         cur,
	input  logic [crb_pkg::OPCODE_W-1:0] opcode,
	input  logic [crb_pkg::STATUS_W-1:0] connect_status,
	input  logic                         so_error_set,
	input  logic                         self_connected,
	input  logic [crb_pkg::DELAY_W-1:0]  init_delay,
	input  logic [crb_pkg::DELAY_W-1:0]  max_delay,
	output crb_pkg::link_state_t         nxt,
	output crb_pkg::action_t             action,
	output logic [crb_pkg::DELAY_W-1:0]  retry_delay
);
	import crb_pkg::*;

	logic [DELAY_W:0]   doubled;
	logic [DELAY_W-1:0] backoff;
	logic               is_proceed;
	logic               is_transient;
	logic               wr_fail;

	// Doubled delay, saturated at the ceiling.
	assign doubled      = {cur.delay, 1'b0};
	assign backoff      = (doubled < {1'b0, max_delay}) ? doubled[DELAY_W-1:0] : max_delay;
	assign is_proceed   = connect_status <= STATUS_PROCEED_MAX;
	assign is_transient = connect_status <= STATUS_TRANSIENT_MAX;
	assign wr_fail      = so_error_set | self_connected;

	always_comb begin
		nxt = cur;
		unique case (opcode)
			OP_START: begin
				nxt.want = 1'b1;
			end
			OP_STOP: begin
				nxt.want = 1'b0;
				if (cur.phase == PH_CONNECTING) nxt.phase = PH_DISC;
			end
			OP_RESTART: begin
				nxt.phase = PH_DISC;
				nxt.want  = 1'b1;
				nxt.delay = init_delay;
			end
			OP_RESULT: begin
				if (cur.phase == PH_DISC) begin
					if (is_proceed) begin
						nxt.phase = PH_CONNECTING;
					end else if (is_transient && cur.want) begin
						nxt.delay = backoff;
					end
				end
			end
			OP_WRITABLE: begin
				if (cur.phase == PH_CONNECTING) begin
					if (wr_fail) begin
						nxt.phase = PH_DISC;
						if (cur.want) nxt.delay = backoff;
					end else begin
						nxt.phase = PH_CONNECTED;
					end
				end
			end
			OP_SOCK_ERR: begin
				if (cur.phase == PH_CONNECTING) begin
					nxt.phase = PH_DISC;
					if (cur.want) nxt.delay = backoff;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		action      = ACT_NONE;
		retry_delay = '0;
		unique case (opcode)
			OP_START: begin
				if (cur.phase == PH_DISC) action = ACT_CONNECT;
			end
			OP_STOP: begin
				// Stop clears the connect wish first, so the retry only closes.
				if (cur.phase == PH_CONNECTING) action = ACT_CLOSE;
			end
			OP_RESTART: begin
				action = ACT_CONNECT;
			end
			OP_RESULT: begin
				if (cur.phase == PH_DISC) begin
					if (is_proceed) begin
						action = ACT_AWAIT;
					end else if (is_transient) begin
						action      = cur.want ? ACT_RETRY : ACT_CLOSE;
						retry_delay = cur.want ? cur.delay : '0;
					end else begin
						action = ACT_PERMANENT;
					end
				end
			end
			OP_WRITABLE: begin
				if (cur.phase == PH_CONNECTING) begin
					if (wr_fail) begin
						action      = cur.want ? ACT_RETRY : ACT_CLOSE;
						retry_delay = cur.want ? cur.delay : '0;
					end else begin
						action = cur.want ? ACT_DELIVER : ACT_CLOSE;
					end
				end
			end
			OP_SOCK_ERR: begin
				if (cur.phase == PH_CONNECTING) begin
					action      = cur.want ? ACT_RETRY : ACT_CLOSE;
					retry_delay = cur.want ? cur.delay : '0;
				end
			end
			OP_TIMER: begin
				if (cur.phase == PH_DISC && cur.want) action = ACT_CONNECT;
			end
			default: ;
		endcase
	end
endmodule

@@ rtl/core/connect_retry_backoff_fsm_core.sv @@
// Top level of the connect retry backoff sequencer.
// An event is registered at its transfer; its action is shown from the action register.
// Throughput: one event per cycle unless the action side stalls; the event register and
// the action register form a two-stage pipe: a new event is taken while an action waits.
// Reset (arst_n, asynchronous): link disconnected, connect wish cleared, delay 500 ms,
// registers at 500 ms and 30000 ms, both channels empty.
`timescale 1ns / 1ps
module connect_retry_backoff_fsm_core (
	input  logic                       clk,
	input  logic                       arst_n,
	crb_evt_if.sink                    evt,
	crb_act_if.source                  act,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [crb_pkg::APB_AW-1:0] paddr,
	input  logic [crb_pkg::APB_DW-1:0] pwdata,
	output logic [crb_pkg::APB_DW-1:0] prdata,
	output logic                       pready
);
	import crb_pkg::*;

	// Configuration register values.
	logic [DELAY_W-1:0] init_delay;
	logic [DELAY_W-1:0] max_delay;

	// Event register (stage 1).
	logic                valid_s1;
	logic [OPCODE_W-1:0] opcode_s1;
	logic [STATUS_W-1:0] status_s1;
	logic                so_err_s1;
	logic                self_s1;

	// Sequencer state and the step logic around it.
	link_state_t        state_q;
	link_state_t        state_nxt;
	action_t            step_action;
	logic [DELAY_W-1:0] step_delay;

	// Action register.
	logic               out_valid_q;
	action_t            action_q;
	logic [DELAY_W-1:0] delay_q;
	phase_t             phase_q;

	logic advance;

	crb_cfg_regs u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.init_delay (init_delay),
		.max_delay  (max_delay)
	);

	crb_step u_step (
		.cur            (state_q),
		.opcode         (opcode_s1),
		.connect_status (status_s1),
		.so_error_set   (so_err_s1),
		.self_connected (self_s1),
		.init_delay     (init_delay),
		.max_delay      (max_delay),
		.nxt            (state_nxt),
		.action         (step_action),
		.retry_delay    (step_delay)
	);

	// The held event is processed when the action register is free or is being
	// emptied by a transfer in the same cycle. State only moves on that edge.
	assign advance   = valid_s1 & (~out_valid_q | act.ready);
	assign evt.ready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt.ready) begin
			valid_s1 <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			opcode_s1 <= evt.opcode;
			status_s1 <= evt.connect_status;
			so_err_s1 <= evt.so_error_set;
			self_s1   <= evt.self_connected;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase <= PH_DISC;
			state_q.want  <= 1'b0;
			state_q.delay <= INIT_DELAY_RESET;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (act.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// The reported link state is the phase after the event.
	always_ff @(posedge clk) begin
		if (advance) begin
			action_q <= step_action;
			delay_q  <= step_delay;
			phase_q  <= state_nxt.phase;
		end
	end

	assign act.valid          = out_valid_q;
	assign act.action         = action_q;
	assign act.retry_delay_ms = delay_q;
	assign act.link_state     = phase_q;

	// A retry never leaves the delay above the ceiling.
	a_delay_capped: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && step_action == ACT_RETRY) |=> (state_q.delay <= max_delay))
		else $error("delay above ceiling after retry");

	// Only a scheduled retry carries a delay.
	a_delay_only_retry: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && action_q != ACT_RETRY) |-> (delay_q == '0))
		else $error("retry delay on a non-retry action");

	// A retry always lands in the disconnected phase.
	a_retry_disc: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && action_q == ACT_RETRY) |-> (phase_q == PH_DISC))
		else $error("retry without disconnect");

	// Delivery and await report the phase they entered.
	a_phase_match: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (action_q == ACT_DELIVER || action_q == ACT_AWAIT)) |->
		((action_q == ACT_DELIVER && phase_q == PH_CONNECTED) ||
		 (action_q == ACT_AWAIT && phase_q == PH_CONNECTING)))
		else $error("reported phase does not match action");

	// The event side stalls only while an event is held and cannot move on.
	a_stall_reason: assert property (@(posedge clk) disable iff (!arst_n)
		!evt.ready |-> (valid_s1 && out_valid_q && !act.ready))
		else $error("event side stalled without cause");
endmodule

@@ tb/crb_action_checker.sv @@
// Predicts the action of every event and checks the action channel against it, and checks register read data.
`timescale 1ns / 1ps
module crb_action_checker
	import crb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	crb_evt_if                evt,
	crb_act_if                act,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	input  logic [APB_DW-1:0] prdata,
	input  logic              pready,
	output int                pending,
	output int                errors
);

	typedef struct packed {
		action_t            action;
		logic [DELAY_W-1:0] delay;
		phase_t             phase;
	} action_outcome_t;

	// Shadow copy of the configuration and of the sequencer state.
	logic [DELAY_W-1:0] init_reg;
	logic [DELAY_W-1:0] max_reg;
	logic [DELAY_W-1:0] delay_now;
	phase_t             link_ph;
	logic               wants;

	action_outcome_t expected_actions[$];
	int              mismatch_count = 0;

	assign errors = mismatch_count;

	// Close the attempt; schedule a retry with the current delay if a link is still wanted.
	function automatic action_t backoff_close(output logic [DELAY_W-1:0] sched);
		logic [DELAY_W:0] doubled;
		sched = '0;
		link_ph = PH_DISC;
		if (!wants) begin
			return ACT_CLOSE;
		end
		sched = delay_now;
		doubled = {delay_now, 1'b0};
		delay_now = (doubled < {1'b0, max_reg}) ? doubled[DELAY_W-1:0] : max_reg;
		return ACT_RETRY;
	endfunction

	function automatic action_outcome_t next_action(logic [OPCODE_W-1:0] op,
			logic [STATUS_W-1:0] status, logic so_err, logic self_conn);
		action_outcome_t    o;
		logic [DELAY_W-1:0] sched;
		o.action = ACT_NONE;
		sched = '0;
		case (op)
			OP_START: begin
				wants = 1'b1;
				if (link_ph == PH_DISC)
					o.action = ACT_CONNECT;
			end
			OP_STOP: begin
				wants = 1'b0;
				if (link_ph == PH_CONNECTING)
					o.action = backoff_close(sched);
			end
			OP_RESTART: begin
				link_ph = PH_DISC;
				delay_now = init_reg;
				wants = 1'b1;
				o.action = ACT_CONNECT;
			end
			OP_RESULT: begin
				if (link_ph == PH_DISC) begin
					if (status <= STATUS_PROCEED_MAX) begin
						link_ph = PH_CONNECTING;
						o.action = ACT_AWAIT;
					end else if (status <= STATUS_TRANSIENT_MAX) begin
						o.action = backoff_close(sched);
					end else begin
						o.action = ACT_PERMANENT;
					end
				end
			end
			OP_WRITABLE: begin
				if (link_ph == PH_CONNECTING) begin
					if (so_err || self_conn) begin
						o.action = backoff_close(sched);
					end else begin
						link_ph = PH_CONNECTED;
						o.action = wants ? ACT_DELIVER : ACT_CLOSE;
					end
				end
			end
			OP_SOCK_ERR: begin
				if (link_ph == PH_CONNECTING)
					o.action = backoff_close(sched);
			end
			OP_TIMER: begin
				if (link_ph == PH_DISC && wants)
					o.action = ACT_CONNECT;
			end
			default: begin
			end
		endcase
		o.delay = sched;
		o.phase = link_ph;
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		action_outcome_t    want_out;
		logic [DELAY_W-1:0] reg_val;
		if (!arst_n) begin
			init_reg = INIT_DELAY_RESET;
			max_reg = MAX_DELAY_RESET;
			delay_now = INIT_DELAY_RESET;
			link_ph = PH_DISC;
			wants = 1'b0;
			expected_actions.delete();
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_INIT_DELAY)
					init_reg = pwdata[DELAY_W-1:0];
				else
					max_reg = pwdata[DELAY_W-1:0];
			end
			if (psel && penable && !pwrite && pready) begin
				reg_val = (paddr[2] == REG_INIT_DELAY) ? init_reg : max_reg;
				if (prdata !== APB_DW'(reg_val)) begin
					$error("prdata: expected %0d, got %0d", reg_val, prdata);
					mismatch_count++;
				end
			end
			// An action leaves only after its event has been registered, so pop before push.
			if (act.valid && act.ready) begin
				if (expected_actions.size() == 0) begin
					$error("action: no action expected, got %0d", act.action);
					mismatch_count++;
				end else begin
					want_out = expected_actions.pop_front();
					if (act.action !== want_out.action) begin
						$error("action: expected %0d, got %0d", want_out.action, act.action);
						mismatch_count++;
					end
					if (act.retry_delay_ms !== want_out.delay) begin
						$error("retry_delay_ms: expected %0d, got %0d", want_out.delay,
							act.retry_delay_ms);
						mismatch_count++;
					end
					if (act.link_state !== want_out.phase) begin
						$error("link_state: expected %0d, got %0d", want_out.phase,
							act.link_state);
						mismatch_count++;
					end
				end
			end
			if (evt.valid && evt.ready)
				expected_actions.push_back(next_action(evt.opcode, evt.connect_status,
					evt.so_error_set, evt.self_connected));
			pending <= expected_actions.size();
		end
	end

endmodule

@@ tb/tb.sv @@
// Top of the testbench: clock, reset, event stimulus, configuration writes and the verdict.
`timescale 1ns / 1ps
module tb;
	import crb_pkg::*;

	// Opcode 7 is not assigned to any event; the block must ignore it.
	localparam logic [OPCODE_W-1:0] OP_UNUSED = 3'd7;

	// How long the action side holds off on request, and the overall run limit.
	localparam int HOLD_CYCLES = 200;
	localparam int RUN_LIMIT   = 400000;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	int pending;
	int mismatches;
	int burst_left;
	int sent_in_phase;
	int hold_off_asked;
	int hold_off_done;
	int cycle_count;

	crb_evt_if evt_ch();
	crb_act_if act_ch();

	connect_retry_backoff_fsm_core u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.evt     (evt_ch),
		.act     (act_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// The checker sits beside the block, watches both channels and the register port,
	// and reports how many actions are still owed and how many mismatches it saw.
	crb_action_checker u_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.evt     (evt_ch),
		.act     (act_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.pending (pending),
		.errors  (mismatches)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Every input gets a known value at time zero. Reset is held from the start and
	// released once, on a rising edge, for the rest of the run.
	initial begin
		arst_n <= 1'b0;
		evt_ch.valid <= 1'b0;
		evt_ch.opcode <= '0;
		evt_ch.connect_status <= '0;
		evt_ch.so_error_set <= 1'b0;
		evt_ch.self_connected <= 1'b0;
		act_ch.ready <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	// The run is cut short if it ever takes far longer than the slowest correct run.
	initial begin
		cycle_count = 0;
		while (cycle_count < RUN_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Verification failed");
		$finish;
	end

	// The action side stalls on a pattern of its own. It switches between several modes
	// (always ready, coin toss, mostly ready, mostly stalled, slow toggling) after spans of
	// random length. When the stimulus asks for it, ready is held low for a long stretch
	// so that the two-stage pipe fills and the event side is back-pressured.
	initial begin
		int mode;
		int span;
		int tick;
		logic rdy;
		hold_off_done = 0;
		tick = 0;
		wait (arst_n === 1'b1);
		forever begin
			mode = $urandom_range(0, 4);
			span = $urandom_range(16, 96);
			repeat (span) begin
				@(posedge clk);
				if (hold_off_asked != hold_off_done) begin
					act_ch.ready <= 1'b0;
					repeat (HOLD_CYCLES) @(posedge clk);
					hold_off_done++;
				end
				tick++;
				case (mode)
					0: rdy = 1'b1;
					1: rdy = 1'($urandom_range(0, 1));
					2: rdy = ($urandom_range(0, 99) < 85);
					3: rdy = ($urandom_range(0, 99) < 15);
					default: rdy = tick[2];
				endcase
				act_ch.ready <= rdy;
			end
		end
	end

	// Offers one event and returns at the edge where its transfer happens. Events go out
	// in bursts of random length; between bursts valid drops for a random gap, and about
	// a third of the gaps are empty so that back-to-back stretches occur as well.
	task automatic send_event(logic [OPCODE_W-1:0] op, logic [STATUS_W-1:0] status,
			logic so_err, logic self_conn);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				evt_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		evt_ch.valid <= 1'b1;
		evt_ch.opcode <= op;
		evt_ch.connect_status <= status;
		evt_ch.so_error_set <= so_err;
		evt_ch.self_connected <= self_conn;
		do @(posedge clk); while (!evt_ch.ready);
		burst_left--;
		sent_in_phase++;
	endtask

	// Stops offering events and waits until the checker owes no action any more. The
	// checker's count is registered, so the first look comes after an edge.
	task automatic drain_actions();
		evt_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (2) @(posedge clk);
		burst_left = 0;
	endtask

	// One register access with a setup and an access cycle. The upper data bits carry
	// noise; only the low sixteen bits belong to a register.
	task automatic apb_access(logic wr, logic idx, logic [DELAY_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= {16'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Registers are only touched with the block idle. Each write is read back.
	task automatic set_delays(logic [DELAY_W-1:0] init_ms, logic [DELAY_W-1:0] max_ms);
		drain_actions();
		apb_access(1'b1, REG_INIT_DELAY, init_ms);
		apb_access(1'b1, REG_MAX_DELAY, max_ms);
		apb_access(1'b0, REG_INIT_DELAY, '0);
		apb_access(1'b0, REG_MAX_DELAY, '0);
	endtask

	// One round of random traffic. Most rounds are a well-formed connection attempt:
	// an opener, a classified connect result, then the outcome of the attempt. Some
	// rounds are a streak of transient failures that drives the delay into its ceiling,
	// and the rest is noise with every field random. Fields that an event does not use
	// are random too.
	task automatic random_round();
		int sel;
		logic [1:0] flags;
		logic [STATUS_W-1:0] status;
		sel = $urandom_range(0, 99);
		if (sel < 15) begin
			send_event(OPCODE_W'($urandom_range(0, 7)), STATUS_W'($urandom),
				1'($urandom), 1'($urandom));
		end else if (sel < 25) begin
			repeat ($urandom_range(6, 18)) begin
				send_event(OP_TIMER, STATUS_W'($urandom), 1'($urandom), 1'($urandom));
				send_event(OP_RESULT, STATUS_W'($urandom_range(4, 8)), 1'($urandom),
					1'($urandom));
			end
		end else begin
			sel = $urandom_range(0, 99);
			send_event(sel < 55 ? OP_START : (sel < 95 ? OP_TIMER : OP_RESTART),
				STATUS_W'($urandom), 1'($urandom), 1'($urandom));
			sel = $urandom_range(0, 99);
			if (sel < 55)
				status = STATUS_W'($urandom_range(0, 3));
			else if (sel < 85)
				status = STATUS_W'($urandom_range(4, 8));
			else
				status = STATUS_W'($urandom_range(9, 31));
			send_event(OP_RESULT, status, 1'($urandom), 1'($urandom));
			sel = $urandom_range(0, 99);
			if (sel < 50) begin
				send_event(OP_WRITABLE, STATUS_W'($urandom), 1'b0, 1'b0);
				// A delivered link only leaves the connected phase through restart.
				if ($urandom_range(0, 9) < 4)
					send_event(OP_RESTART, STATUS_W'($urandom), 1'($urandom),
						1'($urandom));
			end else if (sel < 70) begin
				flags = 2'($urandom_range(1, 3));
				send_event(OP_WRITABLE, STATUS_W'($urandom), flags[1], flags[0]);
			end else if (sel < 85) begin
				send_event(OP_SOCK_ERR, STATUS_W'($urandom), 1'($urandom), 1'($urandom));
			end else if (sel < 95) begin
				send_event(OP_STOP, STATUS_W'($urandom), 1'($urandom), 1'($urandom));
			end
			if ($urandom_range(0, 19) == 0)
				send_event(OP_RESTART, STATUS_W'($urandom), 1'($urandom), 1'($urandom));
		end
	endtask

	// Random rounds until the phase has sent its share of events. Once in a while the
	// sender waits for every owed action before it goes on.
	task automatic run_traffic(int n_items, logic with_hold_off);
		sent_in_phase = 0;
		while (sent_in_phase < n_items) begin
			if (with_hold_off && sent_in_phase >= 40) begin
				hold_off_asked++;
				with_hold_off = 1'b0;
			end
			random_round();
			if ($urandom_range(0, 49) == 0)
				drain_actions();
		end
	endtask

	// Main stimulus: a directed walk through the state machine with the reset values of
	// the registers, then random traffic under a series of delay settings that includes
	// the extremes, a zero delay and a ceiling below the starting delay.
	initial begin
		hold_off_asked = 0;
		burst_left = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);

		// Disconnected with no wish to connect: timer, stop, writable, socket error and the
		// unused opcode are ignored; a transient result just closes without scheduling a retry.
		send_event(OP_TIMER, 5'd0, 1'b0, 1'b0);
		send_event(OP_STOP, 5'd31, 1'b1, 1'b1);
		send_event(OP_WRITABLE, 5'd0, 1'b0, 1'b0);
		send_event(OP_SOCK_ERR, 5'd0, 1'b0, 1'b0);
		send_event(OP_UNUSED, 5'd31, 1'b1, 1'b1);
		send_event(OP_RESULT, 5'd4, 1'b0, 1'b0);
		// Start twice while disconnected, then a transient result schedules a retry.
		send_event(OP_START, 5'd0, 1'b0, 1'b0);
		send_event(OP_START, 5'd0, 1'b0, 1'b0);
		send_event(OP_RESULT, 5'd8, 1'b0, 1'b0);
		send_event(OP_TIMER, 5'd0, 1'b0, 1'b0);
		// Permanent codes, the unexpected code and the largest status value.
		send_event(OP_RESULT, 5'd9, 1'b0, 1'b0);
		send_event(OP_RESULT, 5'd16, 1'b0, 1'b0);
		send_event(OP_RESULT, 5'd31, 1'b0, 1'b0);
		// Into connecting; start and a second result are out of phase there.
		send_event(OP_RESULT, 5'd0, 1'b0, 1'b0);
		send_event(OP_START, 5'd0, 1'b0, 1'b0);
		send_event(OP_RESULT, 5'd0, 1'b0, 1'b0);
		// Each way out of connecting that ends in a retry, with the delay doubling.
		send_event(OP_WRITABLE, 5'd0, 1'b1, 1'b0);
		send_event(OP_RESULT, 5'd3, 1'b0, 1'b0);
		send_event(OP_WRITABLE, 5'd0, 1'b0, 1'b1);
		send_event(OP_RESULT, 5'd1, 1'b0, 1'b0);
		send_event(OP_SOCK_ERR, 5'd0, 1'b0, 1'b0);
		// A clean writable report delivers the link; stop in connected only clears the wish.
		send_event(OP_RESULT, 5'd2, 1'b0, 1'b0);
		send_event(OP_WRITABLE, 5'd0, 1'b0, 1'b0);
		send_event(OP_STOP, 5'd0, 1'b0, 1'b0);
		// Restart, then stop while connecting, then a writable report with no wish to
		// connect, which closes but leaves the phase at connected.
		send_event(OP_RESTART, 5'd0, 1'b0, 1'b0);
		send_event(OP_RESULT, 5'd0, 1'b0, 1'b0);
		send_event(OP_STOP, 5'd0, 1'b0, 1'b0);
		send_event(OP_RESULT, 5'd0, 1'b0, 1'b0);
		send_event(OP_WRITABLE, 5'd0, 1'b0, 1'b0);
		send_event(OP_RESTART, 5'd0, 1'b0, 1'b0);

		// Reset values, with the long hold-off on the action side.
		run_traffic(200, 1'b1);
		set_delays(16'd1, 16'd65535);
		run_traffic(150, 1'b0);
		// Largest delay: doubling overflows sixteen bits and must saturate.
		set_delays(16'd65535, 16'd65535);
		run_traffic(120, 1'b0);
		// Ceiling below the starting delay.
		set_delays(16'd65535, 16'd1);
		run_traffic(100, 1'b1);
		set_delays(16'd0, 16'd0);
		run_traffic(80, 1'b0);
		set_delays(16'd1, 16'd1);
		run_traffic(80, 1'b0);
		repeat (3) begin
			set_delays(($urandom_range(0, 3) == 0) ? DELAY_W'($urandom) :
				DELAY_W'($urandom_range(1, 2000)), DELAY_W'($urandom));
			run_traffic(120, 1'b0);
		end

		drain_actions();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
